// ----- rtl/core/ofb_pkg.sv -----
// Shared types and constants for the overlapping block framer.
package ofb_pkg;

    // Width of sample counts and cell indexes (holds up to 64 frame samples plus one)
    localparam int unsigned CNT_W = 7;
    // Width of the block size and overlap configuration registers
    localparam int unsigned BS_W  = 7;
    localparam int unsigned XR_W  = 6;
    // Output field widths fixed by the frame format
    localparam int unsigned IDX_W = 6;
    localparam int unsigned FNUM_W = 32;

    // Configuration register indexes
    localparam logic REG_BLOCK_SIZE = 1'b0;
    localparam logic REG_EXTRA_RES  = 1'b1;

    // Per-cycle control broadcast from the sequencer to every cell of the chain
    typedef struct packed {
        logic             append;   // load the incoming sample at wr_idx
        logic             shift;    // move every sample one cell towards the head
        logic             keep;     // recirculate the head sample into wr_idx
        logic [CNT_W-1:0] wr_idx;   // target cell for an append or a recirculation
    } t_cell_ctl;

endpackage

// ----- rtl/core/ofb_cell.sv -----
// One storage cell of the sample chain: load, shift from neighbour or recirculate the head.
module ofb_cell #(
    parameter int unsigned SAMPLE_WIDTH = 16,
    parameter int unsigned IDX          = 0
) (
    input  logic                    i_clk,
    input  ofb_pkg::t_cell_ctl      i_ctl,
    input  logic [SAMPLE_WIDTH-1:0] i_sample,
    input  logic [SAMPLE_WIDTH-1:0] i_next,
    input  logic [SAMPLE_WIDTH-1:0] i_head,
    output logic [SAMPLE_WIDTH-1:0] o_data
);
    import ofb_pkg::*;

    logic                    w_hit;
    logic [SAMPLE_WIDTH-1:0] r_data;

    assign w_hit = (i_ctl.wr_idx == CNT_W'(IDX));

    // Hold, load a new sample, take the neighbour's sample or the recirculated head
    always_ff @(posedge i_clk) begin
        if (i_ctl.append && w_hit) begin
            r_data <= i_sample;
        end else if (i_ctl.shift) begin
            if (i_ctl.keep && w_hit) begin
                r_data <= i_head;
            end else begin
                r_data <= i_next;
            end
        end
    end

    assign o_data = r_data;

endmodule

// ----- rtl/core/ofb_ctrl.sv -----
// Sequencer: takes samples, walks the chain once per frame, drops the hop, drives the output register.
module ofb_ctrl #(
    parameter int unsigned SAMPLE_WIDTH = 16,
    parameter int unsigned MAX_FRAME    = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [ofb_pkg::BS_W-1:0]     i_block_size,
    input  logic [ofb_pkg::XR_W-1:0]     i_extra_res,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [SAMPLE_WIDTH-1:0]      i_head,
    output ofb_pkg::t_cell_ctl           o_ctl,
    input  logic                         i_out_ready,
    output logic                         o_out_valid,
    output logic [SAMPLE_WIDTH-1:0]      o_sample,
    output logic [ofb_pkg::IDX_W-1:0]    o_index,
    output logic [ofb_pkg::FNUM_W-1:0]   o_number,
    output logic                         o_last
);
    import ofb_pkg::*;

    typedef enum logic {ST_IDLE, ST_ROT} t_state;

    t_state               r_state;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     r_step;
    logic [CNT_W-1:0]     r_left;
    logic [BS_W:0]        r_acc;
    logic [FNUM_W-1:0]    r_frame;
    logic                 r_out_valid;
    logic [SAMPLE_WIDTH-1:0] r_sample;
    logic [IDX_W-1:0]     r_index;
    logic [FNUM_W-1:0]    r_number;
    logic                 r_last;

    logic [BS_W-1:0]      w_bs;
    logic [BS_W-1:0]      w_div;
    logic                 w_emit;
    logic                 w_step;
    logic                 w_drop;
    logic                 w_load;
    logic                 w_accept;
    logic [CNT_W-1:0]     w_count_inc;

    // Clamp the block size to one frame of at least one sample
    always_comb begin
        if (i_block_size == '0) begin
            w_bs = BS_W'(1);
        end else if (i_block_size > BS_W'(MAX_FRAME)) begin
            w_bs = BS_W'(MAX_FRAME);
        end else begin
            w_bs = i_block_size;
        end
    end

    assign w_div       = BS_W'(i_extra_res) + BS_W'(1);
    assign w_count_inc = r_count + CNT_W'(1);

    // Frame samples leave while the step is below the block size; the rest only recirculate.
    // A sample i is dropped while (i+1)*(extra_resolution+1) <= block size, and always for i = 0.
    assign w_emit   = (r_step < CNT_W'(w_bs));
    assign w_step   = (r_state == ST_ROT) && (!w_emit || !r_out_valid || i_out_ready);
    assign w_drop   = w_emit && ((r_step == '0) || (r_acc <= (BS_W+1)'(w_bs)));
    assign w_load   = w_step && w_emit;
    assign w_accept = i_in_valid && (r_state == ST_IDLE);

    assign o_in_ready = (r_state == ST_IDLE);

    // Broadcast control to the chain
    always_comb begin
        o_ctl.append = w_accept;
        o_ctl.shift  = w_step;
        o_ctl.keep   = !w_drop;
        o_ctl.wr_idx = (r_state == ST_IDLE) ? r_count : (r_count - CNT_W'(1));
    end

    // Sequence state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_frame     <= '0;
            r_out_valid <= 1'b0;
            r_step      <= '0;
            r_left      <= '0;
            r_acc       <= '0;
        end else begin
            // Load the next frame sample or release the one taken
            if (w_load) begin
                r_out_valid <= 1'b1;
                r_sample    <= i_head;
                r_index     <= r_step[IDX_W-1:0];
                r_number    <= r_frame;
                r_last      <= (r_step == CNT_W'(w_bs - BS_W'(1)));
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_count <= w_count_inc;
                        if (w_count_inc > CNT_W'(w_bs)) begin
                            r_frame <= r_frame + FNUM_W'(1);
                            r_state <= ST_ROT;
                            r_left  <= w_count_inc;
                            r_step  <= '0;
                            r_acc   <= (BS_W+1)'(w_div);
                        end
                    end
                end
                ST_ROT: begin
                    if (w_step) begin
                        if (w_drop) begin
                            r_count <= r_count - CNT_W'(1);
                        end
                        // Advance the drop threshold until it passes the block size
                        if (r_acc <= (BS_W+1)'(w_bs)) begin
                            r_acc <= r_acc + (BS_W+1)'(w_div);
                        end
                        r_step <= r_step + CNT_W'(1);
                        r_left <= r_left - CNT_W'(1);
                        if (r_left == CNT_W'(1)) begin
                            r_state <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_sample    = r_sample;
    assign o_index     = r_index;
    assign o_number    = r_number;
    assign o_last      = r_last;

endmodule

// ----- rtl/core/overlapping_block_framer_top.sv -----
// Overlapping block framer top level: configuration registers, sample chain and sequencer.
//
// Usage:
//   s_axis carries one signed sample per transfer. m_axis carries the frames, one sample
//   per transfer, with tlast on the final sample of each frame. Once more than block_size
//   samples are pending, the oldest block_size go out as one frame; then hop =
//   block_size / (extra_resolution + 1) samples (at least one) are dropped from the front.
//   The pending samples live in a chain of MAX_FRAME + 1 cells that shifts towards the head.
//   A sample that completes no frame is taken while the block stays idle. A sample that
//   completes a frame makes the chain rotate once through all P pending samples (P is
//   block_size + 1, or up to MAX_FRAME + 1 while a backlog from a shrunken block_size
//   remains), one cell per cycle unless the receiver stalls; s_axis_tready stays low until
//   the rotation ends. The first frame sample enters the output register on its first step.
//   A stalled receiver halts the rotation while a sample is due; the output register holds.
//   Write i_cfg_* only while the block is idle. Reset empties the chain, zeroes the frame
//   count and sets block_size to 64 and extra_resolution to 0; no clearing pass is needed.
module overlapping_block_framer_top #(
    parameter int unsigned SAMPLE_WIDTH = 16,
    parameter int unsigned MAX_FRAME    = 64
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Configuration write port
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_index,
    input  logic [ofb_pkg::BS_W-1:0]  i_cfg_wdata,
    // Sample input
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,   // sample_in
    // Frame output
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    // sample_out, frame_index, frame_number, zero padding
    output logic [((SAMPLE_WIDTH+ofb_pkg::IDX_W+ofb_pkg::FNUM_W+7)/8)*8-1:0] m_axis_tdata,
    output logic                      m_axis_tlast                // frame_last
);
    import ofb_pkg::*;

    localparam int unsigned NCELL  = MAX_FRAME + 1;
    localparam int unsigned OUT_W  = ((SAMPLE_WIDTH + IDX_W + FNUM_W + 7) / 8) * 8;

    logic [BS_W-1:0]         r_block_size;
    logic [XR_W-1:0]         r_extra_res;
    t_cell_ctl               w_ctl;
    logic [SAMPLE_WIDTH-1:0] w_cell [NCELL];
    logic [SAMPLE_WIDTH-1:0] w_sample;
    logic [IDX_W-1:0]        w_index;
    logic [FNUM_W-1:0]       w_number;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_size <= BS_W'(64);
            r_extra_res  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_BLOCK_SIZE: r_block_size <= i_cfg_wdata;
                REG_EXTRA_RES:  r_extra_res  <= i_cfg_wdata[XR_W-1:0];
                default:        r_block_size <= r_block_size;
            endcase
        end
    end

    // Chain of sample cells, cell 0 holds the oldest pending sample
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        logic [SAMPLE_WIDTH-1:0] w_next;
        if (k < NCELL - 1) begin : g_mid
            assign w_next = w_cell[k+1];
        end else begin : g_end
            assign w_next = '0;
        end
        ofb_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .IDX          (k)
        ) u_cell (
            .i_clk    (i_clk),
            .i_ctl    (w_ctl),
            .i_sample (s_axis_tdata[SAMPLE_WIDTH-1:0]),
            .i_next   (w_next),
            .i_head   (w_cell[0]),
            .o_data   (w_cell[k])
        );
    end

    ofb_ctrl #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .MAX_FRAME    (MAX_FRAME)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_block_size (r_block_size),
        .i_extra_res  (r_extra_res),
        .i_in_valid   (s_axis_tvalid),
        .o_in_ready   (s_axis_tready),
        .i_head       (w_cell[0]),
        .o_ctl        (w_ctl),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_sample     (w_sample),
        .o_index      (w_index),
        .o_number     (w_number),
        .o_last       (m_axis_tlast)
    );

    // Pack the output fields from the lowest bit up
    assign m_axis_tdata = OUT_W'({w_number, w_index, w_sample});

endmodule
